// ===== rtl/gicb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the grid index-to-coordinate block.
// Used by the channel interfaces and by the top level; depends on nothing.
package gicb_pkg;

  localparam int MAX_COLS  = 128;
  localparam int MAX_ROWS  = 128;
  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int IDX_W   = 24;
  localparam int CNT_W   = 8;
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int INT_W   = IDX_W - 1 - FRAC_BITS;

  localparam int CFG_IDX_W = 1;

  localparam int NUM_BANKS   = 4;
  localparam int BANK_SEL_W  = 2;
  localparam int BANK_COL_W  = COL_W - 1;
  localparam int BANK_ROW_W  = ROW_W - 1;
  localparam int BANK_AW     = BANK_COL_W + BANK_ROW_W;
  localparam int BANK_DEPTH  = (MAX_COLS / 2) * (MAX_ROWS / 2);
  localparam int NUM_COORDS  = 2;

  localparam int DIFF_A_W  = COORD_W + 3;
  localparam int DIFF_B_W  = COORD_W + 1;
  localparam int FRAC_OP_W = FRAC_BITS + 1;
  localparam int PROD_A_W  = DIFF_A_W + FRAC_OP_W;
  localparam int PROD_B_W  = DIFF_B_W + FRAC_OP_W;
  localparam int TERM_A_W  = PROD_A_W - FRAC_BITS;
  localparam int TERM_B_W  = PROD_B_W - FRAC_BITS;
  localparam int SUM_W     = TERM_A_W + 2;
  localparam int UV_W      = 2 * FRAC_BITS;

  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS_IN_USE = 1'b0,
    CFG_ROWS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic ok;
    logic u_nz;
    logic v_nz;
    logic i_par;
    logic j_par;
  } corner_sel_t;

endpackage

// ===== rtl/gicb_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on gicb_pkg for field widths.
interface gicb_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [gicb_pkg::COL_W-1:0]           node_col;
  logic [gicb_pkg::ROW_W-1:0]           node_row;
  logic signed [gicb_pkg::COORD_W-1:0]  node_x;
  logic signed [gicb_pkg::COORD_W-1:0]  node_y;
  logic signed [gicb_pkg::IDX_W-1:0]    frac_col;
  logic signed [gicb_pkg::IDX_W-1:0]    frac_row;

  modport source (output valid, req_type, node_col, node_row, node_x, node_y,
                  frac_col, frac_row, input ready);
  modport sink (input valid, req_type, node_col, node_row, node_x, node_y,
                frac_col, frac_row, output ready);
endinterface

interface gicb_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 ok;
  logic signed [gicb_pkg::COORD_W-1:0]  out_x;
  logic signed [gicb_pkg::COORD_W-1:0]  out_y;

  modport source (output valid, ok, out_x, out_y, input ready);
  modport sink (input valid, ok, out_x, out_y, output ready);
endinterface

interface gicb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gicb_pkg::CFG_IDX_W-1:0]   index;
  logic [gicb_pkg::CNT_W-1:0]       wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/grid_index_to_coord_bilinear.sv =====
`timescale 1ns / 1ps
// Curvilinear grid node store with bilinear index-to-coordinate blending.
// Depends on gicb_pkg and the channel interfaces in gicb_if.sv.
//
// The block takes one request per cycle when ready, loads and queries mixed
// in any order. A load writes its node at acceptance and returns nothing.
// A query returns a result; a new query may follow in every cycle unless the
// output stalls. The node stores are split into four banks by column and row
// parity, so the four corners of a cell always sit in distinct banks and are
// read together through one read port per bank. The pipeline stages fill
// independently, so requests keep entering while a result waits at the
// output. The stores are not cleared after reset; a query must touch only
// nodes that were loaded. Register writes are taken in every cycle.
module grid_index_to_coord_bilinear (
  input logic         clk_i,
  input logic         rst_ni,
  gicb_cfg_if.sink    cfg_i,
  gicb_req_if.sink    req_i,
  gicb_rsp_if.source  rsp_o
);

  logic [gicb_pkg::CNT_W-1:0] cols_q, rows_q;
  logic [gicb_pkg::CNT_W-1:0] cols_cl, rows_cl, cols_m1, rows_m1;
  logic [gicb_pkg::INT_W-1:0] col_lim, row_lim;

  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic s1_en, s2_en, s3_en, out_en;
  logic req_acc, ld_acc, qry_acc;

  logic [gicb_pkg::INT_W-1:0]     i_int, j_int;
  logic [gicb_pkg::FRAC_BITS-1:0] u_frac, v_frac;
  logic [gicb_pkg::COL_W-1:0]     q_col;
  logic [gicb_pkg::ROW_W-1:0]     q_row;
  logic                           col_ok, row_ok;
  logic [gicb_pkg::BANK_COL_W-1:0] col_addr [2];
  logic [gicb_pkg::BANK_ROW_W-1:0] row_addr [2];
  logic [gicb_pkg::BANK_AW-1:0]    ld_addr;
  logic [gicb_pkg::BANK_SEL_W-1:0] ld_bank;
  logic [gicb_pkg::BANK_AW-1:0]    bank_addr [gicb_pkg::NUM_BANKS];
  logic                            bank_we [gicb_pkg::NUM_BANKS];
  logic [gicb_pkg::COORD_W-1:0]    rd_data [gicb_pkg::NUM_COORDS][gicb_pkg::NUM_BANKS];

  gicb_pkg::corner_sel_t          s1_sel_q, s1_sel_d;
  logic [gicb_pkg::FRAC_BITS-1:0] s1_u_q, s1_v_q;
  logic [gicb_pkg::UV_W-1:0]      s1_uvp_q;

  logic [gicb_pkg::UV_W:0]        uv_round;
  logic                           s2_ok_q, s3_ok_q;
  logic [gicb_pkg::FRAC_BITS-1:0] s2_u_q, s2_v_q, s2_uv_q;
  logic signed [gicb_pkg::COORD_W-1:0]  s2_p00_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::DIFF_A_W-1:0] s2_a_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::DIFF_B_W-1:0] s2_b_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::DIFF_B_W-1:0] s2_c_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::COORD_W-1:0]  s3_p00_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::PROD_A_W-1:0] s3_pa_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::PROD_B_W-1:0] s3_pb_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::PROD_B_W-1:0] s3_pc_q [gicb_pkg::NUM_COORDS];
  logic signed [gicb_pkg::COORD_W-1:0]  res_d [gicb_pkg::NUM_COORDS];

  logic                                out_ok_q;
  logic signed [gicb_pkg::COORD_W-1:0] out_x_q, out_y_q;

  // Register port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= gicb_pkg::CNT_W'(gicb_pkg::MAX_COLS);
      rows_q <= gicb_pkg::CNT_W'(gicb_pkg::MAX_ROWS);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gicb_pkg::CFG_COLS_IN_USE: cols_q <= cfg_i.wdata;
        gicb_pkg::CFG_ROWS_IN_USE: rows_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_q == '0) begin
      cols_cl = gicb_pkg::CNT_W'(1);
    end else if (cols_q > gicb_pkg::CNT_W'(gicb_pkg::MAX_COLS)) begin
      cols_cl = gicb_pkg::CNT_W'(gicb_pkg::MAX_COLS);
    end else begin
      cols_cl = cols_q;
    end
    if (rows_q == '0) begin
      rows_cl = gicb_pkg::CNT_W'(1);
    end else if (rows_q > gicb_pkg::CNT_W'(gicb_pkg::MAX_ROWS)) begin
      rows_cl = gicb_pkg::CNT_W'(gicb_pkg::MAX_ROWS);
    end else begin
      rows_cl = rows_q;
    end
    cols_m1 = cols_cl - gicb_pkg::CNT_W'(1);
    rows_m1 = rows_cl - gicb_pkg::CNT_W'(1);
    col_lim = cols_m1[gicb_pkg::INT_W-1:0];
    row_lim = rows_m1[gicb_pkg::INT_W-1:0];
  end

  // Each stage moves on when the next one is empty or moving.
  assign out_en      = !out_vld_q || rsp_o.ready;
  assign s3_en       = !s3_vld_q || out_en;
  assign s2_en       = !s2_vld_q || s3_en;
  assign s1_en       = !s1_vld_q || s2_en;
  assign req_i.ready = s1_en;

  assign req_acc = req_i.valid && s1_en;
  assign qry_acc = req_acc && (req_i.req_type == gicb_pkg::REQ_QUERY);
  assign ld_acc  = req_acc && (req_i.req_type == gicb_pkg::REQ_LOAD);

  // Range check and bank addressing of the four corners.
  assign i_int  = req_i.frac_col[gicb_pkg::FRAC_BITS +: gicb_pkg::INT_W];
  assign j_int  = req_i.frac_row[gicb_pkg::FRAC_BITS +: gicb_pkg::INT_W];
  assign u_frac = req_i.frac_col[gicb_pkg::FRAC_BITS-1:0];
  assign v_frac = req_i.frac_row[gicb_pkg::FRAC_BITS-1:0];
  assign q_col  = i_int[gicb_pkg::COL_W-1:0];
  assign q_row  = j_int[gicb_pkg::ROW_W-1:0];

  assign col_ok = !req_i.frac_col[gicb_pkg::IDX_W-1] &&
                  ((i_int < col_lim) || ((i_int == col_lim) && (u_frac == '0)));
  assign row_ok = !req_i.frac_row[gicb_pkg::IDX_W-1] &&
                  ((j_int < row_lim) || ((j_int == row_lim) && (v_frac == '0)));

  assign ld_addr = {req_i.node_row[gicb_pkg::ROW_W-1:1],
                    req_i.node_col[gicb_pkg::COL_W-1:1]};
  assign ld_bank = {req_i.node_row[0], req_i.node_col[0]};

  always_comb begin
    // The even-parity bank holds the column after an odd base column.
    col_addr[0] = q_col[gicb_pkg::COL_W-1:1] + gicb_pkg::BANK_COL_W'(q_col[0]);
    col_addr[1] = q_col[gicb_pkg::COL_W-1:1];
    row_addr[0] = q_row[gicb_pkg::ROW_W-1:1] + gicb_pkg::BANK_ROW_W'(q_row[0]);
    row_addr[1] = q_row[gicb_pkg::ROW_W-1:1];
    for (int b = 0; b < gicb_pkg::NUM_BANKS; b++) begin
      bank_addr[b] = ld_acc ? ld_addr : {row_addr[b[1]], col_addr[b[0]]};
      bank_we[b]   = ld_acc && (ld_bank == gicb_pkg::BANK_SEL_W'(b));
    end
  end

  for (genvar b = 0; b < gicb_pkg::NUM_BANKS; b++) begin : g_bank
    logic [gicb_pkg::COORD_W-1:0] x_mem [gicb_pkg::BANK_DEPTH];
    logic [gicb_pkg::COORD_W-1:0] y_mem [gicb_pkg::BANK_DEPTH];
    logic [gicb_pkg::COORD_W-1:0] x_rd_q, y_rd_q;

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        x_mem[bank_addr[b]] <= req_i.node_x;
        y_mem[bank_addr[b]] <= req_i.node_y;
      end
      if (s1_en) begin
        x_rd_q <= x_mem[bank_addr[b]];
        y_rd_q <= y_mem[bank_addr[b]];
      end
    end

    assign rd_data[0][b] = x_rd_q;
    assign rd_data[1][b] = y_rd_q;
  end

  always_comb begin
    s1_sel_d.ok    = col_ok && row_ok;
    s1_sel_d.u_nz  = (u_frac != '0);
    s1_sel_d.v_nz  = (v_frac != '0);
    s1_sel_d.i_par = q_col[0];
    s1_sel_d.j_par = q_row[0];
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_sel_q <= s1_sel_d;
      s1_u_q   <= u_frac;
      s1_v_q   <= v_frac;
      s1_uvp_q <= u_frac * v_frac;
    end
  end

  // Corner selection and difference terms.
  assign uv_round = {1'b0, s1_uvp_q} + (gicb_pkg::UV_W + 1)'(1 << (gicb_pkg::FRAC_BITS - 1));

  for (genvar k = 0; k < gicb_pkg::NUM_COORDS; k++) begin : g_coord
    logic [gicb_pkg::BANK_SEL_W-1:0]      b00, b01, b10, b11;
    logic signed [gicb_pkg::COORD_W-1:0]  p00, p01, p10, p11;
    logic signed [gicb_pkg::PROD_A_W-1:0] pa_r;
    logic signed [gicb_pkg::PROD_B_W-1:0] pb_r, pc_r;
    logic signed [gicb_pkg::SUM_W-1:0]    sum;

    assign b00 = {s1_sel_q.j_par, s1_sel_q.i_par};
    assign b01 = {s1_sel_q.j_par, ~s1_sel_q.i_par};
    assign b10 = {~s1_sel_q.j_par, s1_sel_q.i_par};
    assign b11 = {~s1_sel_q.j_par, ~s1_sel_q.i_par};

    always_comb begin
      p00 = rd_data[k][b00];
      p01 = s1_sel_q.u_nz ? rd_data[k][b01] : p00;
      p10 = s1_sel_q.v_nz ? rd_data[k][b10] : p00;
      if (s1_sel_q.u_nz) begin
        p11 = s1_sel_q.v_nz ? rd_data[k][b11] : p01;
      end else begin
        p11 = p10;
      end
    end

    always_ff @(posedge clk_i) begin
      if (s2_en) begin
        s2_p00_q[k] <= p00;
        s2_a_q[k]   <= gicb_pkg::DIFF_A_W'(p00) - gicb_pkg::DIFF_A_W'(p01)
                     - gicb_pkg::DIFF_A_W'(p10) + gicb_pkg::DIFF_A_W'(p11);
        s2_b_q[k]   <= gicb_pkg::DIFF_B_W'(p01) - gicb_pkg::DIFF_B_W'(p00);
        s2_c_q[k]   <= gicb_pkg::DIFF_B_W'(p10) - gicb_pkg::DIFF_B_W'(p00);
      end
      if (s3_en) begin
        s3_p00_q[k] <= s2_p00_q[k];
        s3_pa_q[k]  <= s2_a_q[k] * $signed({1'b0, s2_uv_q});
        s3_pb_q[k]  <= s2_b_q[k] * $signed({1'b0, s2_u_q});
        s3_pc_q[k]  <= s2_c_q[k] * $signed({1'b0, s2_v_q});
      end
    end

    // Round half up on each product, then sum and saturate; an out-of-range query gives zero.
    always_comb begin
      pa_r = s3_pa_q[k] + gicb_pkg::PROD_A_W'(1 << (gicb_pkg::FRAC_BITS - 1));
      pb_r = s3_pb_q[k] + gicb_pkg::PROD_B_W'(1 << (gicb_pkg::FRAC_BITS - 1));
      pc_r = s3_pc_q[k] + gicb_pkg::PROD_B_W'(1 << (gicb_pkg::FRAC_BITS - 1));
      sum  = gicb_pkg::SUM_W'(s3_p00_q[k])
           + gicb_pkg::SUM_W'($signed(pa_r[gicb_pkg::PROD_A_W-1:gicb_pkg::FRAC_BITS]))
           + gicb_pkg::SUM_W'($signed(pb_r[gicb_pkg::PROD_B_W-1:gicb_pkg::FRAC_BITS]))
           + gicb_pkg::SUM_W'($signed(pc_r[gicb_pkg::PROD_B_W-1:gicb_pkg::FRAC_BITS]));
      if (!s3_ok_q) begin
        res_d[k] = '0;
      end else if ((&sum[gicb_pkg::SUM_W-1:gicb_pkg::COORD_W-1]) ||
                   !(|sum[gicb_pkg::SUM_W-1:gicb_pkg::COORD_W-1])) begin
        res_d[k] = sum[gicb_pkg::COORD_W-1:0];
      end else if (sum[gicb_pkg::SUM_W-1]) begin
        res_d[k] = {1'b1, {(gicb_pkg::COORD_W-1){1'b0}}};
      end else begin
        res_d[k] = {1'b0, {(gicb_pkg::COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_ok_q <= s1_sel_q.ok;
      s2_u_q  <= s1_u_q;
      s2_v_q  <= s1_v_q;
      s2_uv_q <= uv_round[gicb_pkg::FRAC_BITS +: gicb_pkg::FRAC_BITS];
    end
    if (s3_en) begin
      s3_ok_q <= s2_ok_q;
    end
    if (out_en) begin
      out_ok_q <= s3_ok_q;
      out_x_q  <= res_d[0];
      out_y_q  <= res_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_q <= qry_acc;
      end
      if (s2_en) begin
        s2_vld_q <= s1_vld_q;
      end
      if (s3_en) begin
        s3_vld_q <= s2_vld_q;
      end
      if (out_en) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.ok    = out_ok_q;
  assign rsp_o.out_x = out_x_q;
  assign rsp_o.out_y = out_y_q;

  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_acc |=> !s1_vld_q)
    else $error("A load request entered the result pipeline.");

  a_query_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qry_acc |=> s1_vld_q)
    else $error("An accepted query was dropped.");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_vld_q && s2_vld_q && s3_vld_q && out_vld_q))
    else $error("Requests were refused with an empty pipeline stage.");

  a_bad_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> (rsp_o.out_x == '0 && rsp_o.out_y == '0))
    else $error("An out-of-range result carries nonzero coordinates.");

endmodule

// ===== bench/tb_grid_index_to_coord_bilinear.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_index_to_coord_bilinear: node loads and
// bilinear coordinate queries are checked against an in-bench predictor.
// Depends on gicb_pkg, the channel interfaces in gicb_if.sv and the block.
module tb_grid_index_to_coord_bilinear;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int STORE_DEPTH  = gicb_pkg::MAX_COLS * gicb_pkg::MAX_ROWS;

  typedef struct packed {
    logic                                ok;
    logic signed [gicb_pkg::COORD_W-1:0] x;
    logic signed [gicb_pkg::COORD_W-1:0] y;
  } coord_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gicb_req_if req_if ();
  gicb_rsp_if rsp_if ();
  gicb_cfg_if cfg_if ();

  grid_index_to_coord_bilinear i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic signed [gicb_pkg::COORD_W-1:0] grid_x [STORE_DEPTH];
  logic signed [gicb_pkg::COORD_W-1:0] grid_y [STORE_DEPTH];
  bit                                  node_loaded [STORE_DEPTH];
  logic [gicb_pkg::CNT_W-1:0]          cols_reg = 8'd128;
  logic [gicb_pkg::CNT_W-1:0]          rows_reg = 8'd128;
  coord_result_t                       coord_expect_q [$];

  int cycle_cnt     = 0;
  int fail_cnt      = 0;
  int rsp_hold_left = 0;
  bit src_idle_en   = 1'b1;
  bit sink_idle_en  = 1'b1;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_grid_index_to_coord_bilinear failed");
      $finish;
    end
  end

  function automatic int eff_count(input logic [gicb_pkg::CNT_W-1:0] n, input int maxv);
    if (n == 0) return 1;
    if (int'(n) > maxv) return maxv;
    return int'(n);
  endfunction

  function automatic int node_addr(input int col, input int row);
    return row * gicb_pkg::MAX_COLS + col;
  endfunction

  function automatic longint grid_val(input bit use_y, input int col, input int row);
    if (use_y) return longint'(grid_y[node_addr(col, row)]);
    return longint'(grid_x[node_addr(col, row)]);
  endfunction

  function automatic longint round_q(input longint p);
    return (p + (longint'(1) << (gicb_pkg::FRAC_BITS - 1))) >>> gicb_pkg::FRAC_BITS;
  endfunction

  function automatic void decode_index(input logic signed [gicb_pkg::IDX_W-1:0] fc, fr,
                                       output bit in_grid, output int ci, rj, ci1, rj1,
                                       output longint u, v);
    longint fi;
    longint fj;
    longint lim_i;
    longint lim_j;
    fi = longint'(fc);
    fj = longint'(fr);
    lim_i = longint'(eff_count(cols_reg, gicb_pkg::MAX_COLS) - 1) << gicb_pkg::FRAC_BITS;
    lim_j = longint'(eff_count(rows_reg, gicb_pkg::MAX_ROWS) - 1) << gicb_pkg::FRAC_BITS;
    in_grid = !(fi < 0 || fi > lim_i || fj < 0 || fj > lim_j);
    u = longint'(fc[gicb_pkg::FRAC_BITS-1:0]);
    v = longint'(fr[gicb_pkg::FRAC_BITS-1:0]);
    ci = 0;
    rj = 0;
    if (in_grid) begin
      ci = int'(fi >>> gicb_pkg::FRAC_BITS);
      rj = int'(fj >>> gicb_pkg::FRAC_BITS);
    end
    ci1 = (u != 0) ? ci + 1 : ci;
    rj1 = (v != 0) ? rj + 1 : rj;
  endfunction

  function automatic logic signed [gicb_pkg::COORD_W-1:0] blend_corners(
      input longint p00, p01, p10, p11, u, v, uv);
    longint a;
    longint b;
    longint c;
    longint r;
    a = p00 - p01 - p10 + p11;
    b = p01 - p00;
    c = p10 - p00;
    r = p00 + round_q(a * uv) + round_q(b * u) + round_q(c * v);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[gicb_pkg::COORD_W-1:0];
  endfunction

  function automatic coord_result_t predict_query(
      input logic signed [gicb_pkg::IDX_W-1:0] fc, fr);
    coord_result_t r;
    bit in_grid;
    int ci, rj, ci1, rj1;
    longint u, v, uv;
    decode_index(fc, fr, in_grid, ci, rj, ci1, rj1, u, v);
    r = '0;
    if (in_grid) begin
      uv = round_q(u * v);
      r.ok = 1'b1;
      r.x = blend_corners(grid_val(1'b0, ci, rj), grid_val(1'b0, ci1, rj),
                          grid_val(1'b0, ci, rj1), grid_val(1'b0, ci1, rj1),
                          u, v, uv);
      r.y = blend_corners(grid_val(1'b1, ci, rj), grid_val(1'b1, ci1, rj),
                          grid_val(1'b1, ci, rj1), grid_val(1'b1, ci1, rj1),
                          u, v, uv);
    end
    return r;
  endfunction

  function automatic logic signed [gicb_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [gicb_pkg::IDX_W-1:0] axis_in_range(input int n);
    int k;
    int f;
    k = $urandom_range(0, n - 1);
    f = (k == n - 1 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65535);
    return gicb_pkg::IDX_W'((k << gicb_pkg::FRAC_BITS) | f);
  endfunction

  function automatic logic signed [gicb_pkg::IDX_W-1:0] axis_beyond(input int n);
    case ($urandom_range(0, 2))
      0: return gicb_pkg::IDX_W'(((n - 1) << gicb_pkg::FRAC_BITS) + 1);
      1: return gicb_pkg::IDX_W'(((n - 1) << gicb_pkg::FRAC_BITS)
                                 + $urandom_range(1, 65535));
      default: return {1'b1, 23'($urandom)};
    endcase
  endfunction

  always @(posedge clk_i) begin : result_check
    coord_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (coord_expect_q.size() == 0) begin
        $error("result with no pending request: ok %0b, out_x %0d, out_y %0d",
               rsp_if.ok, rsp_if.out_x, rsp_if.out_y);
        fail_cnt++;
      end else begin
        want = coord_expect_q.pop_front();
        if (rsp_if.ok !== want.ok) begin
          $error("ok mismatch: expected %0b, actual %0b", want.ok, rsp_if.ok);
          fail_cnt++;
        end
        if (rsp_if.out_x !== want.x) begin
          $error("out_x mismatch: expected %0d, actual %0d", want.x, rsp_if.out_x);
          fail_cnt++;
        end
        if (rsp_if.out_y !== want.y) begin
          $error("out_y mismatch: expected %0d, actual %0d", want.y, rsp_if.out_y);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : rsp_ready_ctrl
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_left--;
      end else if (!sink_idle_en) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input gicb_pkg::req_type_e kind,
                              input logic [gicb_pkg::COL_W-1:0] col,
                              input logic [gicb_pkg::ROW_W-1:0] row,
                              input logic signed [gicb_pkg::COORD_W-1:0] x, y,
                              input logic signed [gicb_pkg::IDX_W-1:0] fc, fr);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.node_col <= col;
    req_if.node_row <= row;
    req_if.node_x   <= x;
    req_if.node_y   <= y;
    req_if.frac_col <= fc;
    req_if.frac_row <= fr;
    do @(posedge clk_i); while (!req_if.ready);
    if (kind == gicb_pkg::REQ_LOAD) begin
      grid_x[node_addr(int'(col), int'(row))] = x;
      grid_y[node_addr(int'(col), int'(row))] = y;
      node_loaded[node_addr(int'(col), int'(row))] = 1'b1;
    end else begin
      coord_expect_q.push_back(predict_query(fc, fr));
    end
  endtask

  task automatic send_load(input int col, input int row,
                           input logic signed [gicb_pkg::COORD_W-1:0] x, y);
    send_request(gicb_pkg::REQ_LOAD, gicb_pkg::COL_W'(col), gicb_pkg::ROW_W'(row), x, y,
                 gicb_pkg::IDX_W'($urandom), gicb_pkg::IDX_W'($urandom));
  endtask

  // Loads every corner the query will read that holds no value yet, and at random reloads one that does.
  task automatic send_query(input logic signed [gicb_pkg::IDX_W-1:0] fc, fr);
    bit in_grid;
    int ci, rj, ci1, rj1;
    longint u, v;
    int corner_addr [4];
    decode_index(fc, fr, in_grid, ci, rj, ci1, rj1, u, v);
    if (in_grid) begin
      corner_addr = '{node_addr(ci, rj), node_addr(ci1, rj), node_addr(ci, rj1),
                      node_addr(ci1, rj1)};
      foreach (corner_addr[k]) begin
        if (!node_loaded[corner_addr[k]] || $urandom_range(0, 15) == 0) begin
          send_load(corner_addr[k] % gicb_pkg::MAX_COLS, corner_addr[k] / gicb_pkg::MAX_COLS,
                    rand_coord(), rand_coord());
        end
      end
    end
    send_request(gicb_pkg::REQ_QUERY, gicb_pkg::COL_W'($urandom), gicb_pkg::ROW_W'($urandom),
                 $urandom, $urandom, fc, fr);
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (coord_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grid_size(input logic [gicb_pkg::CNT_W-1:0] ncols, nrows);
    wait_drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= gicb_pkg::CFG_COLS_IN_USE;
    cfg_if.wdata <= ncols;
    do @(posedge clk_i); while (!cfg_if.ready);
    cols_reg = ncols;
    cfg_if.index <= gicb_pkg::CFG_ROWS_IN_USE;
    cfg_if.wdata <= nrows;
    do @(posedge clk_i); while (!cfg_if.ready);
    rows_reg = nrows;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_request();
    int nc;
    int nr;
    logic signed [gicb_pkg::IDX_W-1:0] fc;
    logic signed [gicb_pkg::IDX_W-1:0] fr;
    nc = eff_count(cols_reg, gicb_pkg::MAX_COLS);
    nr = eff_count(rows_reg, gicb_pkg::MAX_ROWS);
    fc = axis_in_range(nc);
    fr = axis_in_range(nr);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        send_load($urandom_range(0, gicb_pkg::MAX_COLS - 1),
                  $urandom_range(0, gicb_pkg::MAX_ROWS - 1), rand_coord(), rand_coord());
        return;
      end
      5: begin
        fc = gicb_pkg::IDX_W'($urandom);
        fr = gicb_pkg::IDX_W'($urandom);
      end
      6: fc = axis_beyond(nc);
      7: fr = axis_beyond(nr);
      default: ;
    endcase
    send_query(fc, fr);
  endtask

  task automatic test_reset_directed();
    send_load(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_load(1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_load(0, 1, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_load(1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_query(24'sh00FFFF, 24'sh00FFFF);
    send_query(24'sh000000, 24'sh000000);
    send_query(24'sh008000, 24'sh000000);
    send_query(24'sh000001, 24'sh00FFFF);
    send_query(24'sh7F0000, 24'sh7F0000);
    send_query(24'sh7E1234, 24'sh7F0000);
    send_query(24'sh050000, 24'sh038000);
    send_query(24'shFFFFFF, 24'sh000000);
    send_query(24'sh000000, 24'sh800000);
    send_query(24'sh7FFFFF, 24'sh000000);
    send_query(24'sh7F0001, 24'sh000000);
    send_query(24'sh000000, 24'sh7F0001);
  endtask

  task automatic test_size_extremes();
    write_grid_size(8'd1, 8'd1);
    send_query(24'sh000000, 24'sh000000);
    send_query(24'sh010000, 24'sh000000);
    send_query(24'sh000000, 24'sh010000);
    send_query(24'sh008000, 24'sh000000);
    write_grid_size(8'd0, 8'd255);
    send_query(24'sh000000, 24'sh7F0000);
    send_query(24'sh000001, 24'sh000000);
    write_grid_size(8'd255, 8'd129);
    send_query(24'sh7F0000, 24'sh7F0000);
    send_query(24'sh7EFFFF, 24'sh7EFFFF);
    write_grid_size(8'd2, 8'd2);
    send_query(24'sh00FFFF, 24'sh00FFFF);
    send_query(24'sh010000, 24'sh010000);
    send_query(24'sh020000, 24'sh000000);
  endtask

  task automatic test_random_phase(input logic [gicb_pkg::CNT_W-1:0] ncols, nrows,
                                   input int count);
    write_grid_size(ncols, nrows);
    repeat (count) random_request();
  endtask

  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    rsp_hold_left = 300;
    repeat (20) send_query(axis_in_range(eff_count(cols_reg, gicb_pkg::MAX_COLS)),
                           axis_in_range(eff_count(rows_reg, gicb_pkg::MAX_ROWS)));
    src_idle_en = 1'b1;
  endtask

  task automatic test_full_rate();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (60) random_request();
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = gicb_pkg::REQ_LOAD;
    req_if.node_col = '0;
    req_if.node_row = '0;
    req_if.node_x = '0;
    req_if.node_y = '0;
    req_if.frac_col = '0;
    req_if.frac_row = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = gicb_pkg::CFG_COLS_IN_USE;
    cfg_if.wdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_directed();
    test_size_extremes();
    test_random_phase(8'd128, 8'd128, 80);
    test_random_phase(8'd3, 8'd7, 60);
    test_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 50);
    test_random_phase(8'd128, 8'd2, 50);
    test_random_phase(8'd2, 8'd128, 50);
    test_random_phase(8'd64, 8'd255, 50);
    test_output_backpressure();
    test_full_rate();

    wait_drain();
    if (fail_cnt == 0) begin
      $display("tb_grid_index_to_coord_bilinear passed");
    end else begin
      $display("tb_grid_index_to_coord_bilinear failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gicb_pkg.sv
rtl/gicb_if.sv
rtl/grid_index_to_coord_bilinear.sv
bench/tb_grid_index_to_coord_bilinear.sv
